/* hw/rtl/tbps_pkg.sv */
package tbps_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;

    localparam int unsigned TOKEN_W = 12;
    localparam int unsigned LABEL_W = 16;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned ENTRY_W = LABEL_W + TOKEN_W;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [TOKEN_W-1:0] BUCKET_DEPTH_RST = TOKEN_W'(10);

    // register index taken from paddr[2]
    localparam logic REG_BUCKET_DEPTH = 1'b0;

    typedef enum logic {
        OP_TOKEN_TICK = 1'b0,
        OP_PACKET     = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        EV_TOKEN_ADDED   = 3'd0,
        EV_TOKEN_DROPPED = 3'd1,
        EV_PKT_QUEUED    = 3'd2,
        EV_PKT_TOO_BIG   = 3'd3,
        EV_QUEUE_FULL    = 3'd4
    } evt_code_t;

    typedef struct packed {
        evt_code_t            event_res;
        logic                 released;
        logic [LABEL_W-1:0]   released_label;
        logic [TOKEN_W-1:0]   released_tokens;
        logic [TOKEN_W-1:0]   bucket_level;
        logic [COUNT_W-1:0]   queue_count;
    } result_t;

endpackage

/* hw/rtl/token_bucket_packet_shaper.sv */
// Each result is registered in the output register or the skid entry.
// Throughput: one item per cycle while s_ready is high; the wait queue head
// is prefetched from the queue RAM each cycle, so back-to-back releases run
// at full rate. A two-entry output buffer keeps s_ready high while one
// result is stalled. Synchronous active-low reset empties the queue and
// bucket, bucket_depth = 10; queue RAM contents are not cleared.
module token_bucket_packet_shaper #(
    parameter int unsigned QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [tbps_pkg::LABEL_W-1:0]        s_packet_label,
    input  logic [tbps_pkg::TOKEN_W-1:0]        s_packet_tokens,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_event_res,
    output logic                                m_released,
    output logic [tbps_pkg::LABEL_W-1:0]        m_released_label,
    output logic [tbps_pkg::TOKEN_W-1:0]        m_released_tokens,
    output logic [tbps_pkg::TOKEN_W-1:0]        m_bucket_level,
    output logic [tbps_pkg::COUNT_W-1:0]        m_queue_count,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tbps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tbps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tbps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TW = tbps_pkg::TOKEN_W;
    localparam int unsigned LW = tbps_pkg::LABEL_W;
    localparam int unsigned EW = tbps_pkg::ENTRY_W;

    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    // configuration
    logic [TW-1:0] depth_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == tbps_pkg::REG_BUCKET_DEPTH);
    assign prdata = (paddr[2] == tbps_pkg::REG_BUCKET_DEPTH)
                    ? tbps_pkg::APB_DATA_W'(depth_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= tbps_pkg::BUCKET_DEPTH_RST;
        end else if (cfg_wr) begin
            depth_reg <= pwdata[TW-1:0];
        end
    end

    // state
    logic [TW-1:0] level_reg, level_next;
    logic [AW-1:0] head_reg, head_next, head_inc;
    logic [AW-1:0] tail_reg, tail_next, tail_inc;
    logic [CW-1:0] fill_reg, fill_next;
    logic          byp_reg;
    logic [EW-1:0] byp_data_reg;
    logic [EW-1:0] ram_rdata;
    logic [EW-1:0] head_entry;
    logic [EW-1:0] in_entry;

    logic              s_accept;
    logic              push, pop;
    tbps_pkg::result_t res;
    tbps_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic [TW-1:0]     lvl_inc;
    logic [31:0]       fill_ext;

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    assign in_entry   = {s_packet_label, s_packet_tokens};
    assign head_entry = byp_reg ? byp_data_reg : ram_rdata;
    assign head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign lvl_inc    = level_reg + 1'b1;

    always_comb begin
        push       = 1'b0;
        pop        = 1'b0;
        level_next = level_reg;
        res        = '0;
        res.event_res = tbps_pkg::EV_TOKEN_ADDED;
        if (s_accept) begin
            if (s_operation == tbps_pkg::OP_TOKEN_TICK) begin
                if (level_reg >= depth_reg) begin
                    res.event_res = tbps_pkg::EV_TOKEN_DROPPED;
                end else begin
                    res.event_res = tbps_pkg::EV_TOKEN_ADDED;
                    level_next    = lvl_inc;
                    if (fill_reg != '0 && lvl_inc >= head_entry[TW-1:0]) begin
                        pop                 = 1'b1;
                        level_next          = lvl_inc - head_entry[TW-1:0];
                        res.released        = 1'b1;
                        res.released_label  = head_entry[EW-1:TW];
                        res.released_tokens = head_entry[TW-1:0];
                    end
                end
            end else begin
                if (s_packet_tokens > depth_reg) begin
                    res.event_res = tbps_pkg::EV_PKT_TOO_BIG;
                end else if (fill_reg >= FULL_CNT) begin
                    res.event_res = tbps_pkg::EV_QUEUE_FULL;
                end else begin
                    res.event_res = tbps_pkg::EV_PKT_QUEUED;
                    push          = 1'b1;
                    if (fill_reg == '0 && level_reg >= s_packet_tokens) begin
                        pop                 = 1'b1;
                        level_next          = level_reg - s_packet_tokens;
                        res.released        = 1'b1;
                        res.released_label  = s_packet_label;
                        res.released_tokens = s_packet_tokens;
                    end
                end
            end
        end
        head_next = pop ? head_inc : head_reg;
        tail_next = push ? tail_inc : tail_reg;
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
        fill_ext         = 32'(fill_next);
        res.bucket_level = level_next;
        res.queue_count  = fill_ext[tbps_pkg::COUNT_W-1:0];
    end

    tbps_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (in_entry),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            byp_reg   <= 1'b0;
        end else begin
            level_reg <= level_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            // entry written this cycle at the next head: RAM read sees old data
            byp_reg   <= push && (tail_reg == head_next);
        end
        byp_data_reg <= in_entry;
    end

    // output register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (s_accept) begin
            skid_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_event_res       = out_reg.event_res;
    assign m_released        = out_reg.released;
    assign m_released_label  = out_reg.released_label;
    assign m_released_tokens = out_reg.released_tokens;
    assign m_bucket_level    = out_reg.bucket_level;
    assign m_queue_count     = out_reg.queue_count;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("queue fill above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with unequal pointers");

    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (fill_reg != '0) || push)
        else $error("release from empty queue");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

endmodule

/* hw/rtl/tbps_ram.sv */
module tbps_ram #(
    parameter int unsigned WIDTH = 28,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
